[rtl/lmsl_pkg.sv]
// shared types and constants for the 3d local minimum seed labeler
package lmsl_pkg;

   localparam int DIM_BITS   = 9;
   localparam int PLANE_BITS = 2 * DIM_BITS;
   localparam int TOTAL_BITS = 3 * DIM_BITS;
   localparam int LAG_BITS   = PLANE_BITS + 1;
   localparam int POS_BITS   = TOTAL_BITS + 1;
   localparam int LABEL_BITS = 25;
   localparam int VALUE_BITS = 16;
   localparam int ADDR_BITS  = 4;
   localparam int DATA_BITS  = 32;
   localparam int DIM_LIMIT  = (1 << DIM_BITS) - 1;
   localparam logic [DIM_BITS-1:0] DIM_RESET = 9'd256;

   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_DEPTH  = 2'd2
   } reg_index_type;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_DRAIN  = 1'b1
   } opcode_type;

   typedef struct packed {
      logic [DIM_BITS-1:0]   w;
      logic [DIM_BITS-1:0]   h;
      logic [DIM_BITS-1:0]   d;
      logic [PLANE_BITS-1:0] wh;
      logic [TOTAL_BITS-1:0] total;
      logic [LAG_BITS-1:0]   lag;
   } dims_type;

   typedef struct packed {
      logic                valid;
      logic                dec;
      logic                last;
      logic [DIM_BITS-1:0] cx;
      logic [DIM_BITS-1:0] cy;
      logic [DIM_BITS-1:0] cz;
   } shift_type;

endpackage

[rtl/lmsl_csr.sv]
// register port and derived volume geometry
module lmsl_csr #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int MAX_DEPTH  = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [lmsl_pkg::ADDR_BITS-1:0]   paddr,
   input  logic [lmsl_pkg::DATA_BITS-1:0]   pwdata,
   output logic [lmsl_pkg::DATA_BITS-1:0]   prdata,
   output logic                             pready,
   output logic                             clear,
   output logic                             busy,
   output lmsl_pkg::dims_type               dims
);

   localparam int MW = (MAX_WIDTH  > lmsl_pkg::DIM_LIMIT) ? lmsl_pkg::DIM_LIMIT : MAX_WIDTH;
   localparam int MH = (MAX_HEIGHT > lmsl_pkg::DIM_LIMIT) ? lmsl_pkg::DIM_LIMIT : MAX_HEIGHT;
   localparam int MD = (MAX_DEPTH  > lmsl_pkg::DIM_LIMIT) ? lmsl_pkg::DIM_LIMIT : MAX_DEPTH;
   localparam logic [lmsl_pkg::DIM_BITS-1:0] MW_C = lmsl_pkg::DIM_BITS'(MW);
   localparam logic [lmsl_pkg::DIM_BITS-1:0] MH_C = lmsl_pkg::DIM_BITS'(MH);
   localparam logic [lmsl_pkg::DIM_BITS-1:0] MD_C = lmsl_pkg::DIM_BITS'(MD);
   localparam logic [1:0] SETTLE_CYCLES = 2'd3;

   logic [lmsl_pkg::DIM_BITS-1:0] w_raw_ff, w_raw_in;
   logic [lmsl_pkg::DIM_BITS-1:0] h_raw_ff, h_raw_in;
   logic [lmsl_pkg::DIM_BITS-1:0] d_raw_ff, d_raw_in;
   lmsl_pkg::dims_type dims_ff, dims_in;
   lmsl_pkg::reg_index_type reg_idx;
   logic wr;
   logic [1:0] settle_ff, settle_in;

   function automatic logic [lmsl_pkg::DIM_BITS-1:0] clamp_dim(
      input logic [lmsl_pkg::DIM_BITS-1:0] v,
      input logic [lmsl_pkg::DIM_BITS-1:0] m
   );
      logic [lmsl_pkg::DIM_BITS-1:0] r;
      if (v == '0) r = lmsl_pkg::DIM_BITS'(1);
      else if (v > m) r = m;
      else r = v;
      return r;
   endfunction

   assign reg_idx = lmsl_pkg::reg_index_type'(paddr[3:2]);
   assign wr      = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      w_raw_in = w_raw_ff;
      h_raw_in = h_raw_ff;
      d_raw_in = d_raw_ff;
      clear    = 1'b0;
      prdata   = '0;
      unique case (reg_idx)
         lmsl_pkg::REG_WIDTH: begin
            prdata = lmsl_pkg::DATA_BITS'(w_raw_ff);
            if (wr) begin
               w_raw_in = pwdata[lmsl_pkg::DIM_BITS-1:0];
               clear    = 1'b1;
            end
         end
         lmsl_pkg::REG_HEIGHT: begin
            prdata = lmsl_pkg::DATA_BITS'(h_raw_ff);
            if (wr) begin
               h_raw_in = pwdata[lmsl_pkg::DIM_BITS-1:0];
               clear    = 1'b1;
            end
         end
         lmsl_pkg::REG_DEPTH: begin
            prdata = lmsl_pkg::DATA_BITS'(d_raw_ff);
            if (wr) begin
               d_raw_in = pwdata[lmsl_pkg::DIM_BITS-1:0];
               clear    = 1'b1;
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   // after a write the geometry settles through registers: clamped dims, then wh, then total and lag
   always_comb begin
      dims_in       = dims_ff;
      dims_in.w     = clamp_dim(w_raw_ff, MW_C);
      dims_in.h     = clamp_dim(h_raw_ff, MH_C);
      dims_in.d     = clamp_dim(d_raw_ff, MD_C);
      dims_in.wh    = dims_ff.w * dims_ff.h;
      dims_in.total = dims_ff.wh * dims_ff.d;
      dims_in.lag   = lmsl_pkg::LAG_BITS'(dims_ff.wh) + lmsl_pkg::LAG_BITS'(dims_ff.w)
                      + lmsl_pkg::LAG_BITS'(1);
   end

   // busy holds until the geometry chain has settled after a register write or reset
   always_comb begin
      settle_in = settle_ff;
      if (clear) settle_in = SETTLE_CYCLES;
      else if (settle_ff != '0) settle_in = settle_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_raw_ff  <= lmsl_pkg::DIM_RESET;
         h_raw_ff  <= lmsl_pkg::DIM_RESET;
         d_raw_ff  <= lmsl_pkg::DIM_RESET;
         settle_ff <= SETTLE_CYCLES;
      end else begin
         w_raw_ff  <= w_raw_in;
         h_raw_ff  <= h_raw_in;
         d_raw_ff  <= d_raw_in;
         settle_ff <= settle_in;
      end
   end

   always_ff @(posedge clock) begin
      dims_ff <= dims_in;
   end

   assign dims = dims_ff;
   assign busy = settle_ff != '0;

endmodule

[rtl/lmsl_sched.sv]
// input tracking, result credits and window shift scheduling
module lmsl_sched #(
   parameter int KEY_BITS = 16,
   parameter int PA_BITS  = 16,
   parameter int LA_BITS  = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               clear,
   input  lmsl_pkg::dims_type                 dims,
   input  logic                               busy,
   input  logic                               en,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_opcode,
   input  logic [lmsl_pkg::VALUE_BITS-1:0]    req_voxel_value,
   output lmsl_pkg::shift_type                iss,
   output logic [KEY_BITS-1:0]                iss_sample,
   output logic [PA_BITS-1:0]                 iss_pa,
   output logic [LA_BITS-1:0]                 iss_la
);

   localparam int TB = lmsl_pkg::TOTAL_BITS;
   localparam int PB = lmsl_pkg::POS_BITS;
   localparam int DB = lmsl_pkg::DIM_BITS;

   logic [TB-1:0] inpos_ff, inpos_in;
   logic [TB-1:0] outpos_ff, outpos_in;
   logic [PB-1:0] credit_ff, credit_in;
   logic [PB-1:0] sc_ff, sc_in;
   logic [TB-1:0] ci_ff, ci_in;
   logic [PA_BITS-1:0] pa_ff, pa_in;
   logic [LA_BITS-1:0] la_ff, la_in;
   logic [DB-1:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic hold_valid_ff, hold_valid_in;
   logic [KEY_BITS-1:0] hold_data_ff, hold_data_in;
   logic [KEY_BITS-1:0] key;

   logic accept, store, emit, can, take, need_sample, is_dec, last;
   logic [PB-1:0] inpos_new, need_raw, need, total_x;

   assign key = KEY_BITS'(req_voxel_value);

   assign total_x     = PB'(dims.total);
   assign need_sample = sc_ff < total_x;
   assign is_dec      = sc_ff >= PB'(dims.lag);
   assign last        = is_dec && ((PB'(ci_ff) + PB'(1)) == total_x);
   assign can         = en && !busy && (!need_sample || hold_valid_ff)
                        && (!is_dec || credit_ff != '0);
   assign take        = can && need_sample;
   assign req_stall   = busy || (hold_valid_ff && !take);
   assign accept      = req_valid && !req_stall;

   // mirror of the volume bookkeeping, decides which transfers owe a result
   assign store     = (req_opcode == lmsl_pkg::OP_SAMPLE) && (inpos_ff < dims.total);
   assign inpos_new = PB'(inpos_ff) + PB'(store);
   assign need_raw  = PB'(outpos_ff) + PB'(dims.lag) + PB'(1);
   assign need      = (need_raw > total_x) ? total_x : need_raw;
   assign emit      = accept && (outpos_ff < dims.total) && (inpos_new >= need);

   always_comb begin
      inpos_in      = inpos_ff;
      outpos_in     = outpos_ff;
      hold_valid_in = hold_valid_ff;
      hold_data_in  = hold_data_ff;
      if (take) hold_valid_in = 1'b0;
      if (accept && store) begin
         hold_valid_in = 1'b1;
         hold_data_in  = key;
         inpos_in      = inpos_new[TB-1:0];
      end
      if (emit) begin
         if ((PB'(outpos_ff) + PB'(1)) == total_x) begin
            inpos_in  = '0;
            outpos_in = '0;
         end else begin
            outpos_in = outpos_ff + TB'(1);
         end
      end
      credit_in = credit_ff + PB'(emit) - PB'(can && is_dec);
   end

   always_comb begin
      sc_in = sc_ff;
      ci_in = ci_ff;
      pa_in = pa_ff;
      la_in = la_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      cz_in = cz_ff;
      if (can) begin
         sc_in = sc_ff + PB'(1);
         if ((lmsl_pkg::PLANE_BITS+1)'(pa_ff) + (lmsl_pkg::PLANE_BITS+1)'(1)
             == (lmsl_pkg::PLANE_BITS+1)'(dims.wh)) pa_in = '0;
         else pa_in = pa_ff + PA_BITS'(1);
         if ((DB+1)'(la_ff) + (DB+1)'(1) == (DB+1)'(dims.w)) la_in = '0;
         else la_in = la_ff + LA_BITS'(1);
         if (is_dec) begin
            ci_in = ci_ff + TB'(1);
            if (cx_ff + DB'(1) == dims.w) begin
               cx_in = '0;
               if (cy_ff + DB'(1) == dims.h) begin
                  cy_in = '0;
                  cz_in = cz_ff + DB'(1);
               end else begin
                  cy_in = cy_ff + DB'(1);
               end
            end else begin
               cx_in = cx_ff + DB'(1);
            end
         end
         if (last) begin
            sc_in = '0;
            ci_in = '0;
            pa_in = '0;
            la_in = '0;
            cx_in = '0;
            cy_in = '0;
            cz_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         inpos_ff      <= '0;
         outpos_ff     <= '0;
         credit_ff     <= '0;
         hold_valid_ff <= 1'b0;
         sc_ff         <= '0;
         ci_ff         <= '0;
         pa_ff         <= '0;
         la_ff         <= '0;
         cx_ff         <= '0;
         cy_ff         <= '0;
         cz_ff         <= '0;
      end else begin
         inpos_ff      <= inpos_in;
         outpos_ff     <= outpos_in;
         credit_ff     <= credit_in;
         hold_valid_ff <= hold_valid_in;
         sc_ff         <= sc_in;
         ci_ff         <= ci_in;
         pa_ff         <= pa_in;
         la_ff         <= la_in;
         cx_ff         <= cx_in;
         cy_ff         <= cy_in;
         cz_ff         <= cz_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_data_ff <= hold_data_in;
   end

   always_comb begin
      iss.valid = can;
      iss.dec   = is_dec;
      iss.last  = last;
      iss.cx    = cx_ff;
      iss.cy    = cy_ff;
      iss.cz    = cz_ff;
   end

   // shifts past the end of the volume carry filler
   assign iss_sample = need_sample ? hold_data_ff : '0;
   assign iss_pa     = pa_ff;
   assign iss_la     = la_ff;

endmodule

[rtl/lmsl_window.sv]
// plane and line delay memories, 3x3x3 window, decision and output register
module lmsl_window #(
   parameter int KEY_BITS    = 16,
   parameter int PLANE_DEPTH = 65536,
   parameter int LINE_DEPTH  = 256,
   parameter int PA_BITS     = 16,
   parameter int LA_BITS     = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               clear,
   input  lmsl_pkg::dims_type                 dims,
   input  lmsl_pkg::shift_type                iss,
   input  logic [KEY_BITS-1:0]                iss_sample,
   input  logic [PA_BITS-1:0]                 iss_pa,
   input  logic [LA_BITS-1:0]                 iss_la,
   output logic                               en,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [lmsl_pkg::LABEL_BITS-1:0]    rsp_seed_label,
   output logic                               rsp_is_seed,
   output logic                               rsp_last_voxel
);

   localparam int KB = KEY_BITS;
   localparam int DB = lmsl_pkg::DIM_BITS;

   logic [2*KB-1:0] plane_mem [PLANE_DEPTH];
   logic [6*KB-1:0] line_mem [LINE_DEPTH];

   lmsl_pkg::shift_type s1_ff, s2_ff, s3_ff;
   logic [KB-1:0]      s1_sample_ff;
   logic [PA_BITS-1:0] s1_pa_ff;
   logic [LA_BITS-1:0] s1_la_ff, s2_la_ff;
   logic [KB-1:0]      s2_t_ff [3];

   logic [2*KB-1:0] plane_rd_ff, plane_fwd_data_ff, plane_word, plane_wr;
   logic            plane_fwd_ff;
   logic [6*KB-1:0] line_rd_ff, line_fwd_data_ff, line_word, line_wr;
   logic            line_fwd_ff;
   logic [KB-1:0]   stream [9];
   logic [KB-1:0]   win_ff [27];

   logic rsp_valid_ff, rsp_valid_in;
   logic [lmsl_pkg::LABEL_BITS-1:0] label_ff, label_in;
   logic is_seed_ff, is_seed_in, last_ff, last_in;
   logic [lmsl_pkg::LABEL_BITS-1:0] seed_cnt_ff, seed_cnt_in;
   logic seed;
   logic in_x [3];
   logic in_y [3];
   logic in_z [3];

   // whole engine holds while a result waits
   assign en = !(rsp_valid_ff && rsp_stall);

   // plane delay: entry keeps samples one and two planes back
   assign plane_word = plane_fwd_ff ? plane_fwd_data_ff : plane_rd_ff;
   assign plane_wr   = {s1_sample_ff, plane_word[2*KB-1:KB]};

   always_ff @(posedge clock) begin
      if (en) begin
         if (iss.valid) plane_rd_ff <= plane_mem[iss_pa];
         if (s1_ff.valid) plane_mem[s1_pa_ff] <= plane_wr;
         plane_fwd_ff      <= s1_ff.valid && (s1_pa_ff == iss_pa);
         plane_fwd_data_ff <= plane_wr;
      end
   end

   // line delay: per plane stream, samples one and two rows back
   assign line_word = line_fwd_ff ? line_fwd_data_ff : line_rd_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         line_wr[a*2*KB +: 2*KB] = {s2_t_ff[a], line_word[a*2*KB+KB +: KB]};
         stream[a*3]             = s2_t_ff[a];
         stream[a*3+1]           = line_word[a*2*KB+KB +: KB];
         stream[a*3+2]           = line_word[a*2*KB +: KB];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (s1_ff.valid) line_rd_ff <= line_mem[s1_la_ff];
         if (s2_ff.valid) line_mem[s2_la_ff] <= line_wr;
         line_fwd_ff      <= s2_ff.valid && (s2_la_ff == s1_la_ff);
         line_fwd_data_ff <= line_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_sample_ff <= iss_sample;
         s1_pa_ff     <= iss_pa;
         s1_la_ff     <= iss_la;
         s2_la_ff     <= s1_la_ff;
         s2_t_ff[0]   <= s1_sample_ff;
         s2_t_ff[1]   <= plane_word[2*KB-1:KB];
         s2_t_ff[2]   <= plane_word[KB-1:0];
         if (s2_ff.valid) begin
            for (int r = 0; r < 9; r++) begin
               win_ff[r*3]   <= stream[r];
               win_ff[r*3+1] <= win_ff[r*3];
               win_ff[r*3+2] <= win_ff[r*3+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
         s3_ff <= '0;
      end else if (en) begin
         s1_ff <= iss;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
      end
   end

   // window index 0 is the +1 side, index 2 the -1 side
   always_comb begin
      in_x[0] = ((DB+1)'(s3_ff.cx) + (DB+1)'(1)) < (DB+1)'(dims.w);
      in_x[1] = 1'b1;
      in_x[2] = s3_ff.cx != '0;
      in_y[0] = ((DB+1)'(s3_ff.cy) + (DB+1)'(1)) < (DB+1)'(dims.h);
      in_y[1] = 1'b1;
      in_y[2] = s3_ff.cy != '0;
      in_z[0] = ((DB+1)'(s3_ff.cz) + (DB+1)'(1)) < (DB+1)'(dims.d);
      in_z[1] = 1'b1;
      in_z[2] = s3_ff.cz != '0;
   end

   always_comb begin
      seed = 1'b1;
      for (int a = 0; a < 3; a++) begin
         for (int b = 0; b < 3; b++) begin
            for (int c = 0; c < 3; c++) begin
               if (!(a == 1 && b == 1 && c == 1) && in_z[a] && in_y[b] && in_x[c]
                   && !(win_ff[13] < win_ff[a*9+b*3+c])) seed = 1'b0;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      label_in     = label_ff;
      is_seed_in   = is_seed_ff;
      last_in      = last_ff;
      seed_cnt_in  = seed_cnt_ff;
      if (en) begin
         rsp_valid_in = s3_ff.valid && s3_ff.dec;
         label_in     = seed ? seed_cnt_ff + lmsl_pkg::LABEL_BITS'(1) : '0;
         is_seed_in   = seed;
         last_in      = s3_ff.last;
         if (s3_ff.valid && s3_ff.dec) begin
            if (s3_ff.last) seed_cnt_in = '0;
            else if (seed) seed_cnt_in = seed_cnt_ff + lmsl_pkg::LABEL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         seed_cnt_ff  <= '0;
      end else if (clear) begin
         rsp_valid_ff <= rsp_valid_in;
         seed_cnt_ff  <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         seed_cnt_ff  <= seed_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      label_ff   <= label_in;
      is_seed_ff <= is_seed_in;
      last_ff    <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_seed_label = label_ff;
   assign rsp_is_seed    = is_seed_ff;
   assign rsp_last_voxel = last_ff;

endmodule

[rtl/local_minimum_seed_labeler_3d.sv]
// a voxel's result passes the input hold register, s1, s2, s3 and the output register after its completing transfer
// throughput: one transfer per cycle unless busy, a held sample or a stalled result holds it; after the volume
// each further transfer releases one result; rate is set by the plane and line delay memories, one read and one
// write each per cycle; past the volume end the window shifts w*h+w+1 filler samples, decided ones on a result credit
// reset is synchronous: geometry returns to 256 cubed, valids clear, input stalls until the geometry settles
// a register write restarts the volume and stalls input until the geometry settles; memories are not cleared
module local_minimum_seed_labeler_3d #(
   parameter int MAX_WIDTH   = 256,
   parameter int MAX_HEIGHT  = 256,
   parameter int MAX_DEPTH   = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_opcode,
   input  logic [lmsl_pkg::VALUE_BITS-1:0]    req_voxel_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [lmsl_pkg::LABEL_BITS-1:0]    rsp_seed_label,
   output logic                               rsp_is_seed,
   output logic                               rsp_last_voxel,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [lmsl_pkg::ADDR_BITS-1:0]     paddr,
   input  logic [lmsl_pkg::DATA_BITS-1:0]     pwdata,
   output logic [lmsl_pkg::DATA_BITS-1:0]     prdata,
   output logic                               pready
);

   localparam int KEY_BITS = (SAMPLE_BITS < lmsl_pkg::VALUE_BITS) ? SAMPLE_BITS
                                                                    : lmsl_pkg::VALUE_BITS;
   localparam int PW = (MAX_WIDTH  > lmsl_pkg::DIM_LIMIT) ? lmsl_pkg::DIM_LIMIT : MAX_WIDTH;
   localparam int PH = (MAX_HEIGHT > lmsl_pkg::DIM_LIMIT) ? lmsl_pkg::DIM_LIMIT : MAX_HEIGHT;
   localparam int PLANE_DEPTH = PW * PH;
   localparam int LINE_DEPTH  = PW;
   localparam int PA_BITS = $clog2(PLANE_DEPTH);
   localparam int LA_BITS = $clog2(LINE_DEPTH);

   lmsl_pkg::dims_type  dims;
   lmsl_pkg::shift_type iss;
   logic clear, en, busy;
   logic [KEY_BITS-1:0] iss_sample;
   logic [PA_BITS-1:0]  iss_pa;
   logic [LA_BITS-1:0]  iss_la;

   lmsl_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_DEPTH  (MAX_DEPTH)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .clear   (clear),
      .busy    (busy),
      .dims    (dims)
   );

   lmsl_sched #(
      .KEY_BITS (KEY_BITS),
      .PA_BITS  (PA_BITS),
      .LA_BITS  (LA_BITS)
   ) u_sched (
      .clock           (clock),
      .reset           (reset),
      .clear           (clear),
      .dims            (dims),
      .busy            (busy),
      .en              (en),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_voxel_value (req_voxel_value),
      .iss             (iss),
      .iss_sample      (iss_sample),
      .iss_pa          (iss_pa),
      .iss_la          (iss_la)
   );

   lmsl_window #(
      .KEY_BITS    (KEY_BITS),
      .PLANE_DEPTH (PLANE_DEPTH),
      .LINE_DEPTH  (LINE_DEPTH),
      .PA_BITS     (PA_BITS),
      .LA_BITS     (LA_BITS)
   ) u_window (
      .clock          (clock),
      .reset          (reset),
      .clear          (clear),
      .dims           (dims),
      .iss            (iss),
      .iss_sample     (iss_sample),
      .iss_pa         (iss_pa),
      .iss_la         (iss_la),
      .en             (en),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_seed_label (rsp_seed_label),
      .rsp_is_seed    (rsp_is_seed),
      .rsp_last_voxel (rsp_last_voxel)
   );

endmodule

[rtl/lmsl_checker.sv]
// port-level checks for the seed labeler, bound to the top level
module lmsl_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [lmsl_pkg::LABEL_BITS-1:0] rsp_seed_label,
   input logic                            rsp_is_seed,
   input logic                            pready
);

   // nothing comes out in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a labeled result and a seed flag always agree
   a_label_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_seed == (rsp_seed_label != '0)))
      else $error("seed flag and label disagree");

   // a stalled transfer keeps its payload
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_seed_label) && $stable(rsp_is_seed))
      else $error("stalled result changed");

   // register port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind local_minimum_seed_labeler_3d lmsl_checker u_lmsl_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_seed_label (rsp_seed_label),
   .rsp_is_seed    (rsp_is_seed),
   .pready         (pready)
);
